/* hdl/btbe_pkg.sv */
// Package: shared types, constants and opcodes for the three band equalizer.
package btbe_pkg;
  localparam int SampleBitsDef = 24;
  localparam int RegBits = 17;
  localparam int PhaseBits = 18;
  localparam logic [PhaseBits-1:0] PhaseOne = 18'd65536;
  localparam int AddrBits = 5;

  typedef enum logic [4:0] {
    REG_TREBLE = 5'd0,
    REG_MID    = 5'd4,
    REG_BASS   = 5'd8,
    REG_STEP_A = 5'd12,
    REG_STEP_B = 5'd16
  } reg_addr_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PHASE, ST_BEZ, ST_MIX, ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;      // capture input beat, advance phases
    logic       bez_step;  // run one bezier step
    logic [3:0] bez_idx;   // step index
    logic       mix_step;  // run one mix step
    logic [2:0] mix_idx;
    logic       out_load;
  } cmd_t;
endpackage

/* hdl/btbe_ctrl.sv */
// Controller: sequences one sample pair through the shared datapath.
module btbe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             out_busy,
  output btbe_pkg::cmd_t   cmd
);
  import btbe_pkg::*;
  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_PHASE;
      ST_PHASE: begin
        state_nxt = ST_BEZ;
        cnt_nxt   = '0;
      end
      ST_BEZ: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = ST_MIX;
          cnt_nxt   = '0;
        end
      end
      ST_MIX: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd5) state_nxt = ST_OUT;
      end
      ST_OUT: if (!out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = (state_r == ST_IDLE);
    cmd.load     = (state_r == ST_IDLE) && in_tvalid;
    cmd.bez_step = (state_r == ST_BEZ);
    cmd.bez_idx  = cnt_r;
    cmd.mix_step = (state_r == ST_MIX);
    cmd.mix_idx  = cnt_r[2:0];
    cmd.out_load = (state_r == ST_OUT) && !out_busy;
  end
endmodule

/* hdl/btbe_datapath.sv */
// Datapath: phases, histories, a multiplier pair shared by the Bezier steps, and band mix.
module btbe_datapath #(
  parameter int SAMPLE_BITS = btbe_pkg::SampleBitsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  btbe_pkg::cmd_t                cmd,
  input  logic signed [SAMPLE_BITS-1:0] in_l,
  input  logic signed [SAMPLE_BITS-1:0] in_r,
  input  logic [btbe_pkg::RegBits-1:0]  treble_gain,
  input  logic [btbe_pkg::RegBits-1:0]  mid_gain,
  input  logic [btbe_pkg::RegBits-1:0]  bass_gain,
  input  logic [btbe_pkg::RegBits-1:0]  step_a,
  input  logic [btbe_pkg::RegBits-1:0]  step_b,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [SAMPLE_BITS-1:0]        out_l,
  output logic [SAMPLE_BITS-1:0]        out_r
);
  import btbe_pkg::*;
  localparam int SB = SAMPLE_BITS;
  localparam int WB = SB + 3;          // bezier intermediates
  localparam int AW = SB + 24;         // products/accumulator
  localparam logic signed [SB-1:0] MaxV = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] MinV = {1'b1, {(SB-1){1'b0}}};

  logic [PhaseBits-1:0] ph_u_r, ph_l_r;
  logic signed [SB-1:0] hu_r [6];
  logic signed [SB-1:0] hl_r [6];
  logic signed [SB-1:0] xl_r, xr_r;
  logic signed [WB-1:0] cb_r, ba_r;
  logic signed [WB-1:0] sm_r [4];      // up_l, up_r, low_l, low_r
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic                 out_tvalid_r;
  logic [SB-1:0]        out_l_r, out_r_r;

  logic [PhaseBits-1:0] pu_sum, pl_sum;
  always_comb begin
    pu_sum = ph_u_r + {1'b0, step_a};
    pl_sum = ph_l_r + {1'b0, step_b};
  end

  // bezier step: idx[3:2] selects smoother output, idx[1:0] sub-step
  logic [1:0]            bsel;
  logic [PhaseBits-1:0]  t, u;
  logic signed [SB-1:0]  hc, hb, ha;
  logic signed [WB-1:0]  ma0, ma1;
  logic signed [AW-1:0]  p0, p1, psum, rshift16, rshift17;
  always_comb begin
    bsel = cmd.bez_idx[3:2];
    t  = bsel[1] ? ph_l_r : ph_u_r;
    u  = PhaseOne - t;
    hc = bsel[1] ? (bsel[0] ? hl_r[3] : hl_r[0]) : (bsel[0] ? hu_r[3] : hu_r[0]);
    hb = bsel[1] ? (bsel[0] ? hl_r[4] : hl_r[1]) : (bsel[0] ? hu_r[4] : hu_r[1]);
    ha = bsel[1] ? (bsel[0] ? hl_r[5] : hl_r[2]) : (bsel[0] ? hu_r[5] : hu_r[2]);
    case (cmd.bez_idx[1:0])
      2'd0: begin ma0 = WB'(hc); ma1 = WB'(hb); end
      2'd1: begin ma0 = WB'(hb); ma1 = WB'(ha); end
      default: begin ma0 = cb_r; ma1 = ba_r; end
    endcase
    p0 = AW'(ma0) * $signed({1'b0, u});
    p1 = AW'(ma1) * $signed({1'b0, t});
    psum = p0 + p1;
    rshift16 = (psum + AW'(32768)) >>> 16;
    rshift17 = (psum + (AW'(hb) <<< 16) + AW'(65536)) >>> 17;
  end

  // mix: acc += band * gain, channels interleaved step by step
  logic                 mch;
  logic signed [WB-1:0] bin, bup, blow, band;
  logic [RegBits-1:0]   gain;
  logic signed [AW-1:0] rnd;
  always_comb begin
    mch  = cmd.mix_idx[0];
    bin  = mch ? WB'(xr_r) : WB'(xl_r);
    bup  = mch ? sm_r[1] : sm_r[0];
    blow = mch ? sm_r[3] : sm_r[2];
    case (cmd.mix_idx[2:1])
      2'd0: begin band = blow; gain = bass_gain; end
      2'd1: begin band = bup - blow; gain = mid_gain; end
      default: begin band = bin - bup; gain = treble_gain; end
    endcase
    acc_nxt = acc_r + AW'(band) * $signed({1'b0, gain});
    rnd = (acc_r + AW'(8192)) >>> 14;
  end

  logic signed [SB-1:0] sat;
  always_comb begin
    if (rnd > AW'(MaxV)) sat = MaxV;
    else if (rnd < AW'(MinV)) sat = MinV;
    else sat = rnd[SB-1:0];
  end

  // mix order: interleaved; use separate accumulators per channel
  logic signed [AW-1:0] accr_r;
  logic signed [AW-1:0] rndr;
  logic signed [SB-1:0] satr;
  always_comb begin
    rndr = (accr_r + AW'(8192)) >>> 14;
    if (rndr > AW'(MaxV)) satr = MaxV;
    else if (rndr < AW'(MinV)) satr = MinV;
    else satr = rndr[SB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_u_r <= '0;
      ph_l_r <= '0;
      for (int i = 0; i < 6; i++) begin
        hu_r[i] <= '0;
        hl_r[i] <= '0;
      end
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        xl_r <= in_l;
        xr_r <= in_r;
        if (pu_sum > PhaseOne) begin
          ph_u_r <= '0;
          hu_r[0] <= hu_r[1]; hu_r[1] <= hu_r[2]; hu_r[2] <= in_l;
          hu_r[3] <= hu_r[4]; hu_r[4] <= hu_r[5]; hu_r[5] <= in_r;
        end else ph_u_r <= pu_sum;
        if (pl_sum > PhaseOne) begin
          ph_l_r <= '0;
          hl_r[0] <= hl_r[1]; hl_r[1] <= hl_r[2]; hl_r[2] <= in_l;
          hl_r[3] <= hl_r[4]; hl_r[4] <= hl_r[5]; hl_r[5] <= in_r;
        end else ph_l_r <= pl_sum;
        acc_r  <= '0;
        accr_r <= '0;
      end
      if (cmd.bez_step) begin
        case (cmd.bez_idx[1:0])
          2'd0: cb_r <= rshift16[WB-1:0];
          2'd1: ba_r <= rshift16[WB-1:0];
          default: sm_r[bsel] <= rshift17[WB-1:0];
        endcase
      end
      if (cmd.mix_step) begin
        if (mch) accr_r <= acc_nxt - acc_r + accr_r;
        else acc_r <= acc_nxt;
      end
      if (cmd.out_load) begin
        out_l_r <= sat;
        out_r_r <= satr;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_comb begin
    out_tvalid = out_tvalid_r;
    out_l = out_l_r;
    out_r = out_r_r;
  end
endmodule

/* hdl/bezier_three_band_eq.sv */
// Top level: three band stereo equalizer with APB register port.
// Channel   | Beat content                           | Handshake
// in        | tdata = left_sample, right_sample       | tvalid/tready
// out       | tdata = left_result, right_result       | tvalid/tready
// cfg       | gains, phase steps                      | APB, pready high
// One sample pair passes through accept, phase update, 16 Bezier steps on a
// shared multiplier pair, 6 mix steps and output load.
// Reset is synchronous; phases, histories and registers return to defaults.
// A stalled output keeps the finished pair in the accumulators and the
// input not ready until the output register is free.
module bezier_three_band_eq #(
  parameter int SAMPLE_BITS = btbe_pkg::SampleBitsDef
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [2*SAMPLE_BITS-1:0] in_tdata,   // left_sample, right_sample
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [2*SAMPLE_BITS-1:0] out_tdata,  // left_result, right_result
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [btbe_pkg::AddrBits-1:0] cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);
  import btbe_pkg::*;
  logic [RegBits-1:0] treble_r, mid_r, bass_r, stepa_r, stepb_r;
  cmd_t cmd;
  logic [SAMPLE_BITS-1:0] ol, orr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      treble_r <= 17'd16384;
      mid_r    <= 17'd16384;
      bass_r   <= 17'd16384;
      stepa_r  <= 17'd6554;
      stepb_r  <= 17'd655;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr)
        REG_TREBLE: treble_r <= cfg_pwdata[RegBits-1:0];
        REG_MID:    mid_r    <= cfg_pwdata[RegBits-1:0];
        REG_BASS:   bass_r   <= cfg_pwdata[RegBits-1:0];
        REG_STEP_A: stepa_r  <= cfg_pwdata[RegBits-1:0];
        REG_STEP_B: stepb_r  <= cfg_pwdata[RegBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_pready = 1'b1;
    case (cfg_paddr)
      REG_TREBLE: cfg_prdata = 32'(treble_r);
      REG_MID:    cfg_prdata = 32'(mid_r);
      REG_BASS:   cfg_prdata = 32'(bass_r);
      REG_STEP_A: cfg_prdata = 32'(stepa_r);
      REG_STEP_B: cfg_prdata = 32'(stepb_r);
      default:    cfg_prdata = '0;
    endcase
  end

  btbe_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_busy(out_tvalid && !out_tready), .cmd(cmd)
  );

  btbe_datapath #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_l(in_tdata[SAMPLE_BITS-1:0]), .in_r(in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .treble_gain(treble_r), .mid_gain(mid_r), .bass_gain(bass_r),
    .step_a(stepa_r), .step_b(stepb_r),
    .out_tready(out_tready), .out_tvalid(out_tvalid), .out_l(ol), .out_r(orr)
  );

  assign out_tdata = {orr, ol};
endmodule
